>>> rtl/clr_pkg.sv
// Shared types, widths and register codes for the clipped line rasterizer.
package clr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int FRAME_BITS  = 15;
  localparam int STRIDE_BITS = 18;
  localparam int BPP_BITS    = 4;
  localparam int OFFSET_BITS = 32;
  localparam int PROD_BITS   = COORD_BITS - 1 + STRIDE_BITS;
  localparam int CMP_BITS    = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = STRIDE_BITS;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_STRIDE     = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_BYTES_PER_PIXEL = CFG_IDX_BITS'(3);

  localparam logic [BPP_BITS-1:0] BPP_RESET = BPP_BITS'(4);

  typedef struct packed {
    logic [FRAME_BITS-1:0]  frame_width;
    logic [FRAME_BITS-1:0]  frame_height;
    logic [STRIDE_BITS-1:0] line_stride;
    logic [BPP_BITS-1:0]    bytes_per_pixel;
  } cfg_regs_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    logic                          is_step;
    logic signed [COORD_BITS-1:0]  x0;
    logic signed [COORD_BITS-1:0]  y0;
    logic signed [COORD_BITS-1:0]  x1;
    logic signed [COORD_BITS-1:0]  y1;
    logic [COORD_BITS-1:0]         abs_dx;
    logic signed [DELTA_BITS-1:0]  neg_abs_dy;
    logic                          sx_neg;
    logic                          sy_neg;
  } cmd_entry_t;

endpackage

>>> rtl/clr_if.sv
// Channel interfaces: command input, pixel output and register write port.
interface clr_cmd_if import clr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clr_pix_if import clr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         inside_res;
  logic [OFFSET_BITS-1:0]       byte_offset;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, inside_res, byte_offset, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, inside_res, byte_offset, last,
                output ready);
endinterface

interface clr_cfg_if import clr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/clr_front.sv
// Front end: classifies requests and computes line setup (deltas, step signs).
module clr_front import clr_pkg::*; (
  clr_cmd_if.sink    cmd,
  output logic       push_valid,
  output cmd_entry_t push_entry,
  input  logic       push_ready
);

  logic signed [DELTA_BITS-1:0] ddx;
  logic signed [DELTA_BITS-1:0] ddy;
  logic signed [DELTA_BITS-1:0] abs_dx_w;

  assign cmd.ready  = push_ready;
  assign push_valid = cmd.valid;

  always_comb begin
    ddx = {cmd.end_x[COORD_BITS-1], cmd.end_x} - {cmd.start_x[COORD_BITS-1], cmd.start_x};
    ddy = {cmd.end_y[COORD_BITS-1], cmd.end_y} - {cmd.start_y[COORD_BITS-1], cmd.start_y};
    abs_dx_w = ddx[DELTA_BITS-1] ? -ddx : ddx;

    push_entry.is_step    = (cmd.opcode == OP_STEP);
    push_entry.x0         = cmd.start_x;
    push_entry.y0         = cmd.start_y;
    push_entry.x1         = cmd.end_x;
    push_entry.y1         = cmd.end_y;
    push_entry.abs_dx     = abs_dx_w[COORD_BITS-1:0];
    push_entry.neg_abs_dy = ddy[DELTA_BITS-1] ? ddy : -ddy;
    // step goes negative unless start lies strictly below end
    push_entry.sx_neg     = !(cmd.start_x < cmd.end_x);
    push_entry.sy_neg     = !(cmd.start_y < cmd.end_y);
  end

endmodule

>>> rtl/clr_queue.sv
// Short register queue between the front end and the stepping back end.
module clr_queue import clr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push_valid,
  input  cmd_entry_t                push_entry,
  output logic                      push_ready,
  output logic                      not_empty,
  output cmd_entry_t                head,
  input  logic                      pop,
  output logic [QUEUE_PTR_BITS:0]   count
);

  cmd_entry_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic                      push;
  logic                      do_pop;

  assign push_ready = (count != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
  assign not_empty  = (count != '0);
  assign head       = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (QUEUE_PTR_BITS + 1)'(push) - (QUEUE_PTR_BITS + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> rtl/clr_back.sv
// Back end: Bresenham stepper, clip test and byte offset pipeline.
module clr_back import clr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg_regs,
  input  logic       not_empty,
  input  cmd_entry_t head,
  output logic       pop,
  clr_pix_if.source  pix
);

  // line state
  logic signed [COORD_BITS-1:0] pos_x, pos_y, target_x, target_y;
  logic [COORD_BITS-1:0]        abs_dx;
  logic signed [DELTA_BITS-1:0] neg_abs_dy;
  logic signed [ERR_BITS-1:0]   err, delta_sum;
  logic                         sx_neg, sy_neg, active;

  // step stage
  logic                         s1_valid, s1_inside, s1_last;
  logic signed [COORD_BITS-1:0] s1_x, s1_y;
  // multiply stage
  logic                         s2_valid, s2_inside, s2_last;
  logic signed [COORD_BITS-1:0] s2_x, s2_y;
  logic [PROD_BITS-1:0]         s2_prod_y, s2_prod_x;

  logic                         advance, take, emit;
  logic signed [ERR_BITS:0]     twice, nady_w, adx_w;
  logic signed [ERR_BITS-1:0]   nady_e, adx_e, load_err, err_add;
  logic                         move_x, move_y, at_end, in_frame;
  logic [CMP_BITS-1:0]          ux, uy;

  assign advance = !pix.valid || pix.ready;
  assign pop     = not_empty && advance;
  assign take    = pop;
  assign emit    = take && head.is_step && active;

  always_comb begin
    nady_e   = {{(ERR_BITS - DELTA_BITS){neg_abs_dy[DELTA_BITS-1]}}, neg_abs_dy};
    adx_e    = {{(ERR_BITS - COORD_BITS){1'b0}}, abs_dx};
    twice    = {err, 1'b0};
    nady_w   = {nady_e[ERR_BITS-1], nady_e};
    adx_w    = {1'b0, adx_e};
    move_x   = (twice >= nady_w);
    move_y   = (twice <= adx_w);
    unique case ({move_x, move_y})
      2'b11:   err_add = delta_sum;
      2'b10:   err_add = nady_e;
      2'b01:   err_add = adx_e;
      default: err_add = '0;
    endcase
    load_err = {{(ERR_BITS - COORD_BITS){1'b0}}, head.abs_dx}
             + {{(ERR_BITS - DELTA_BITS){head.neg_abs_dy[DELTA_BITS-1]}}, head.neg_abs_dy};
    at_end   = (pos_x == target_x) && (pos_y == target_y);
    ux       = CMP_BITS'(unsigned'(pos_x));
    uy       = CMP_BITS'(unsigned'(pos_y));
    in_frame = !pos_x[COORD_BITS-1] && !pos_y[COORD_BITS-1]
            && (ux < CMP_BITS'(cfg_regs.frame_width))
            && (uy < CMP_BITS'(cfg_regs.frame_height));
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pix.valid <= 1'b0;
    end else begin
      if (take) begin
        if (!head.is_step) begin
          active <= 1'b1;
        end else if (active && at_end) begin
          active <= 1'b0;
        end
      end
      if (advance) begin
        s1_valid  <= emit;
        s2_valid  <= s1_valid;
        pix.valid <= s2_valid;
      end
    end
  end

  // line registers; reset to zero to mirror the idle state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      target_x   <= '0;
      target_y   <= '0;
      abs_dx     <= '0;
      neg_abs_dy <= '0;
      err        <= '0;
      delta_sum  <= '0;
      sx_neg     <= 1'b0;
      sy_neg     <= 1'b0;
    end else if (take && !head.is_step) begin
      pos_x      <= head.x0;
      pos_y      <= head.y0;
      target_x   <= head.x1;
      target_y   <= head.y1;
      abs_dx     <= head.abs_dx;
      neg_abs_dy <= head.neg_abs_dy;
      err        <= load_err;
      delta_sum  <= load_err;
      sx_neg     <= head.sx_neg;
      sy_neg     <= head.sy_neg;
    end else if (emit && !at_end) begin
      err <= err + err_add;
      if (move_x) begin
        pos_x <= sx_neg ? pos_x - 1'b1 : pos_x + 1'b1;
      end
      if (move_y) begin
        pos_y <= sy_neg ? pos_y - 1'b1 : pos_y + 1'b1;
      end
    end
  end

  // pixel payload pipeline
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x      <= pos_x;
      s1_y      <= pos_y;
      s1_inside <= in_frame;
      s1_last   <= at_end;

      s2_x      <= s1_x;
      s2_y      <= s1_y;
      s2_inside <= s1_inside;
      s2_last   <= s1_last;
      s2_prod_y <= PROD_BITS'(s1_y[COORD_BITS-2:0]) * PROD_BITS'(cfg_regs.line_stride);
      s2_prod_x <= PROD_BITS'(s1_x[COORD_BITS-2:0]) * PROD_BITS'(cfg_regs.bytes_per_pixel);

      pix.pixel_x     <= s2_x;
      pix.pixel_y     <= s2_y;
      pix.inside_res  <= s2_inside;
      pix.last        <= s2_last;
      pix.byte_offset <= s2_inside ? OFFSET_BITS'(s2_prod_y + s2_prod_x) : '0;
    end
  end

endmodule

>>> rtl/clipped_line_rasterizer.sv
// Top level of the clipped Bresenham line rasterizer.
//
//   channel | dir | payload                                          | takes
//   --------+-----+--------------------------------------------------+---------------------
//   cmd     | in  | opcode, start_x, start_y, end_x, end_y           | valid && ready
//   pix     | out | pixel_x, pixel_y, inside_res, byte_offset, last  | valid && ready
//   cfg     | in  | reg_index, wdata                                 | valid && ready (always)
//
// Sustained rate: one request per clock while pix is not stalled; each step request of an
// active line gives one pixel, from the Bresenham update in the back end.
// From cmd acceptance a request passes the queue, then the step, multiply and output
// registers before pixel valid; the queue write shares the accepting edge.
// rst is synchronous, active high: clears queue, pipeline valids and line state,
// and loads register defaults (bytes_per_pixel = 4, others 0).
// A stalled pix freezes the back-end pipeline; the 2-entry queue absorbs requests
// so cmd.ready drops only once it fills.
module clipped_line_rasterizer import clr_pkg::*; (
  input logic       clk,
  input logic       rst,
  clr_cmd_if.sink   cmd,
  clr_pix_if.source pix,
  clr_cfg_if.sink   cfg
);

  cfg_regs_t                cfg_regs;
  logic                     push_valid;
  cmd_entry_t               push_entry;
  logic                     push_ready;
  logic                     not_empty;
  cmd_entry_t               head;
  logic                     pop;
  logic [QUEUE_PTR_BITS:0]  q_count;

  // register file; the user must write only while idle, as the block has no hazard checks
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.frame_width     <= '0;
      cfg_regs.frame_height    <= '0;
      cfg_regs.line_stride     <= '0;
      cfg_regs.bytes_per_pixel <= BPP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_FRAME_WIDTH:     cfg_regs.frame_width     <= cfg.wdata[FRAME_BITS-1:0];
        REG_FRAME_HEIGHT:    cfg_regs.frame_height    <= cfg.wdata[FRAME_BITS-1:0];
        REG_LINE_STRIDE:     cfg_regs.line_stride     <= cfg.wdata[STRIDE_BITS-1:0];
        REG_BYTES_PER_PIXEL: cfg_regs.bytes_per_pixel <= cfg.wdata[BPP_BITS-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // classify and set up
  clr_front u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // decouple front from back
  clr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .count      (q_count)
  );

  // step, clip, offset
  clr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .pix       (pix)
  );

`ifndef NO_ASSERTIONS
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> q_count != '0)
    else $error("accepted request missing from queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_clip_offset: assert property (@(posedge clk) disable iff (rst)
    pix.valid && !pix.inside_res |-> pix.byte_offset == '0)
    else $error("clipped pixel carries an offset");
`endif

endmodule
